### hdl/mlc_pkg.sv
`default_nettype none
package mlc_pkg;

  localparam int NumSets = 64;
  localparam int SetW    = $clog2(NumSets);
  localparam int AddrW   = 32;
  localparam int OffW    = 5;
  localparam int TagW    = AddrW - OffW - SetW;
  localparam int WordW   = 64;
  localparam int DatIdxW = SetW + 3;

  localparam logic [1:0] ST_M = 2'd0;
  localparam logic [1:0] ST_E = 2'd1;
  localparam logic [1:0] ST_S = 2'd2;
  localparam logic [1:0] ST_I = 2'd3;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_FILL  = 2'd2;
  localparam logic [1:0] REQ_SNOOP = 2'd3;

  localparam logic [1:0] SNP_BUSRD = 2'd0;

  localparam logic [2:0] RESP_LOADHIT   = 3'd0;
  localparam logic [2:0] RESP_STOREDONE = 3'd1;
  localparam logic [2:0] RESP_MISS      = 3'd2;
  localparam logic [2:0] RESP_FILLBUF   = 3'd3;
  localparam logic [2:0] RESP_INSTALLED = 3'd4;
  localparam logic [2:0] RESP_SNOOP     = 3'd5;
  localparam logic [2:0] RESP_FLUSH     = 3'd6;

  localparam logic [2:0] MSG_NONE   = 3'd0;
  localparam logic [2:0] MSG_BUSRD  = 3'd1;
  localparam logic [2:0] MSG_BUSRDX = 3'd2;
  localparam logic [2:0] MSG_UPGR   = 3'd3;
  localparam logic [2:0] MSG_FLUSH  = 3'd4;

  typedef struct packed {
    logic       cap;
    logic       eval;
    logic       st_we;
    logic [1:0] st_val;
    logic       lru_we;
    logic       tag_we;
    logic       dat_we;
    logic       dat_fill;
    logic       dat_re;
    logic       cnt_sel;
    logic [1:0] cnt;
    logic       fb_we;
    logic       emit;
    logic [2:0] resp;
    logic [2:0] msg;
    logic [1:0] lstate;
    logic [1:0] fwi;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       wi3;
    logic       shared;
    logic [1:0] kind;
    logic       hit;
    logic [1:0] cur_st;
  } stat_t;

endpackage
`default_nettype wire

### hdl/mlc_dpath.sv
`default_nettype none
module mlc_dpath (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire  [1:0]                  in_req_type,
  input  wire  [mlc_pkg::AddrW-1:0]   in_addr,
  input  wire  [mlc_pkg::WordW-1:0]   in_write_data,
  input  wire  [1:0]                  in_word_index,
  input  wire                         in_shared,
  input  wire  [1:0]                  in_snoop_kind,
  input  wire                         cfg_we,
  input  wire  [3:0]                  cfg_wdata,
  input  mlc_pkg::cmd_t               cmd,
  output mlc_pkg::stat_t              stat,
  output logic                        out_strobe,
  output logic [2:0]                  out_resp,
  output logic [mlc_pkg::WordW-1:0]   out_read_data,
  output logic [2:0]                  out_bus_msg,
  output logic [mlc_pkg::AddrW-1:0]   out_bus_addr,
  output logic [3:0]                  out_requester_id,
  output logic [1:0]                  out_flush_word_index,
  output logic [1:0]                  out_line_state,
  output logic                        out_last
);

  typedef logic [1:0][mlc_pkg::TagW-1:0] tag_row_t;
  typedef logic [1:0][1:0]               st_row_t;

  logic [mlc_pkg::AddrW-1:0] addr_r;
  logic [mlc_pkg::WordW-1:0] wd_r;
  logic [1:0]                type_r, wi_r, kind_r;
  logic                      shared_r;
  logic [3:0]                node_r;
  logic                      way_r;

  tag_row_t tag_mem [mlc_pkg::NumSets];
  st_row_t  st_mem  [mlc_pkg::NumSets];
  logic     lru_mem [mlc_pkg::NumSets];
  logic [mlc_pkg::WordW-1:0] dat_mem [mlc_pkg::NumSets*8];
  logic [mlc_pkg::NumSets-1:0] st_vld_r, lru_vld_r;

  tag_row_t tag_q;
  st_row_t  st_q;
  logic     st_vld_q, lru_q, lru_vld_q;
  logic [mlc_pkg::WordW-1:0] rd_q;
  logic [mlc_pkg::WordW-1:0] fbuf_r [3];

  logic [mlc_pkg::SetW-1:0] set_r, set_in;
  logic [mlc_pkg::TagW-1:0] tag_r;
  logic [1:0]               word_r, wsel;
  st_row_t                  st_row, st_new;
  tag_row_t                 tag_new;
  logic                     lru, hit0, hit1, tgt, act_way;
  logic [mlc_pkg::DatIdxW-1:0] didx;
  logic [mlc_pkg::WordW-1:0]   dwr;
  logic [mlc_pkg::AddrW-1:0]   fbase;

  assign set_in = in_addr[mlc_pkg::OffW +: mlc_pkg::SetW];
  assign set_r  = addr_r[mlc_pkg::OffW +: mlc_pkg::SetW];
  assign tag_r  = addr_r[mlc_pkg::AddrW-1 -: mlc_pkg::TagW];
  assign word_r = addr_r[4:3];

  assign st_row = st_vld_q ? st_q : {mlc_pkg::ST_I, mlc_pkg::ST_I};
  assign lru    = lru_vld_q & lru_q;
  assign hit0   = (st_row[0] != mlc_pkg::ST_I) && (tag_q[0] == tag_r);
  assign hit1   = (st_row[1] != mlc_pkg::ST_I) && (tag_q[1] == tag_r);

  always_comb begin
    if (hit0)                          tgt = 1'b0;
    else if (hit1)                     tgt = 1'b1;
    else if (st_row[0] == mlc_pkg::ST_I) tgt = 1'b0;
    else if (st_row[1] == mlc_pkg::ST_I) tgt = 1'b1;
    else                               tgt = lru;
  end

  assign act_way = cmd.eval ? tgt : way_r;

  always_comb begin
    st_new  = st_row;
    st_new[act_way] = cmd.st_val;
    tag_new = tag_q;
    tag_new[act_way] = tag_r;
  end

  assign wsel  = cmd.cnt_sel ? cmd.cnt : word_r;
  assign didx  = {set_r, act_way, wsel};
  assign fbase = {tag_q[act_way], set_r, {mlc_pkg::OffW{1'b0}}};

  always_comb begin
    if (!cmd.dat_fill) begin
      dwr = wd_r;
    end else begin
      case (cmd.cnt)
        2'd0:    dwr = fbuf_r[0];
        2'd1:    dwr = fbuf_r[1];
        2'd2:    dwr = fbuf_r[2];
        default: dwr = wd_r;
      endcase
    end
  end

  assign stat.req_type = type_r;
  assign stat.wi3      = (wi_r == 2'd3);
  assign stat.shared   = shared_r;
  assign stat.kind     = kind_r;
  assign stat.hit      = hit0 | hit1;
  assign stat.cur_st   = st_row[act_way];

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      addr_r   <= in_addr;
      wd_r     <= in_write_data;
      type_r   <= in_req_type;
      wi_r     <= in_word_index;
      shared_r <= in_shared;
      kind_r   <= in_snoop_kind;
      tag_q    <= tag_mem[set_in];
      st_q     <= st_mem[set_in];
      lru_q    <= lru_mem[set_in];
    end
    if (cmd.eval) way_r <= tgt;
    if (cmd.tag_we) tag_mem[set_r] <= tag_new;
    if (cmd.st_we)  st_mem[set_r]  <= st_new;
    if (cmd.lru_we) lru_mem[set_r] <= ~act_way;
    if (cmd.dat_we) dat_mem[didx] <= dwr;
    if (cmd.dat_re) rd_q <= dat_mem[didx];
    if (cmd.fb_we) begin
      case (wi_r)
        2'd0:    fbuf_r[0] <= wd_r;
        2'd1:    fbuf_r[1] <= wd_r;
        default: fbuf_r[2] <= wd_r;
      endcase
    end
  end

  // valid bits stand in for the all-Invalid and all-zero reset of the rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r  <= '0;
      lru_vld_r <= '0;
      st_vld_q  <= 1'b0;
      lru_vld_q <= 1'b0;
      node_r    <= 4'd0;
    end else begin
      if (cmd.cap) begin
        st_vld_q  <= st_vld_r[set_in];
        lru_vld_q <= lru_vld_r[set_in];
      end
      if (cmd.st_we)  st_vld_r[set_r]  <= 1'b1;
      if (cmd.lru_we) lru_vld_r[set_r] <= 1'b1;
      if (cfg_we) node_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe           <= 1'b0;
      out_resp             <= 3'd0;
      out_read_data        <= '0;
      out_bus_msg          <= mlc_pkg::MSG_NONE;
      out_bus_addr         <= '0;
      out_requester_id     <= 4'd0;
      out_flush_word_index <= 2'd0;
      out_line_state       <= mlc_pkg::ST_I;
      out_last             <= 1'b0;
    end else begin
      out_strobe <= cmd.emit;
      if (cmd.emit) begin
        out_resp <= cmd.resp;
        out_read_data <= (cmd.resp == mlc_pkg::RESP_LOADHIT ||
                          cmd.resp == mlc_pkg::RESP_FLUSH) ? rd_q : '0;
        out_bus_msg <= cmd.msg;
        if (cmd.msg == mlc_pkg::MSG_NONE)       out_bus_addr <= '0;
        else if (cmd.msg == mlc_pkg::MSG_FLUSH) out_bus_addr <= fbase;
        else                                    out_bus_addr <= addr_r;
        out_requester_id     <= (cmd.msg == mlc_pkg::MSG_NONE) ? 4'd0 : node_r;
        out_flush_word_index <= cmd.fwi;
        out_line_state       <= cmd.lstate;
        out_last             <= cmd.last;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/mlc_ctrl.sv
`default_nettype none
module mlc_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  output logic            busy,
  input  mlc_pkg::stat_t  stat,
  output mlc_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_LDOUT = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt, cnt_m1;
  logic [1:0] ns_r, ns_nxt, fill_ns, snp_ns;
  logic       fill_r, fill_nxt, fl_r, fl_nxt;

  assign busy    = (state_r != S_IDLE);
  assign cnt_m1  = cnt_r - 3'd1;
  assign fill_ns = stat.shared ? mlc_pkg::ST_S : mlc_pkg::ST_E;

  always_comb begin
    if (stat.kind != mlc_pkg::SNP_BUSRD)
      snp_ns = mlc_pkg::ST_I;
    else if (stat.cur_st == mlc_pkg::ST_M || stat.cur_st == mlc_pkg::ST_E)
      snp_ns = mlc_pkg::ST_S;
    else
      snp_ns = stat.cur_st;
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ns_nxt    = ns_r;
    fill_nxt  = fill_r;
    fl_nxt    = fl_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        cmd.last = 1'b1;
        unique case (stat.req_type)
          mlc_pkg::REQ_LOAD: begin
            if (!stat.hit) begin
              cmd.emit   = 1'b1;
              cmd.resp   = mlc_pkg::RESP_MISS;
              cmd.msg    = mlc_pkg::MSG_BUSRD;
              cmd.lstate = mlc_pkg::ST_I;
              state_nxt  = S_IDLE;
            end else begin
              cmd.lru_we = 1'b1;
              cmd.dat_re = 1'b1;
              state_nxt  = S_LDOUT;
            end
          end
          mlc_pkg::REQ_STORE: begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
            if (!stat.hit) begin
              cmd.resp   = mlc_pkg::RESP_MISS;
              cmd.msg    = mlc_pkg::MSG_BUSRDX;
              cmd.lstate = mlc_pkg::ST_I;
            end else begin
              cmd.st_we  = 1'b1;
              cmd.st_val = mlc_pkg::ST_M;
              cmd.dat_we = 1'b1;
              cmd.lru_we = 1'b1;
              cmd.resp   = mlc_pkg::RESP_STOREDONE;
              cmd.msg    = (stat.cur_st == mlc_pkg::ST_S) ? mlc_pkg::MSG_UPGR
                                                          : mlc_pkg::MSG_NONE;
              cmd.lstate = mlc_pkg::ST_M;
            end
          end
          mlc_pkg::REQ_FILL: begin
            if (!stat.wi3) begin
              cmd.fb_we  = 1'b1;
              cmd.emit   = 1'b1;
              cmd.resp   = mlc_pkg::RESP_FILLBUF;
              cmd.lstate = stat.hit ? stat.cur_st : mlc_pkg::ST_I;
              state_nxt  = S_IDLE;
            end else begin
              ns_nxt   = fill_ns;
              fill_nxt = 1'b1;
              cnt_nxt  = 3'd0;
              // a miss landing on an M way flushes the victim first
              fl_nxt   = !stat.hit && (stat.cur_st == mlc_pkg::ST_M);
              state_nxt = fl_nxt ? S_FLUSH : S_WRITE;
            end
          end
          default: begin
            if (!stat.hit) begin
              cmd.emit   = 1'b1;
              cmd.resp   = mlc_pkg::RESP_SNOOP;
              cmd.lstate = mlc_pkg::ST_I;
              state_nxt  = S_IDLE;
            end else begin
              cmd.st_we  = 1'b1;
              cmd.st_val = snp_ns;
              if (stat.cur_st == mlc_pkg::ST_M) begin
                ns_nxt    = snp_ns;
                fill_nxt  = 1'b0;
                cnt_nxt   = 3'd0;
                state_nxt = S_FLUSH;
              end else begin
                cmd.emit   = 1'b1;
                cmd.resp   = mlc_pkg::RESP_SNOOP;
                cmd.lstate = snp_ns;
                state_nxt  = S_IDLE;
              end
            end
          end
        endcase
      end
      S_LDOUT: begin
        cmd.emit   = 1'b1;
        cmd.resp   = mlc_pkg::RESP_LOADHIT;
        cmd.lstate = stat.cur_st;
        cmd.last   = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_FLUSH: begin
        // read word n while the previous word leaves as a beat
        cmd.cnt_sel = 1'b1;
        cmd.cnt     = cnt_r[1:0];
        cmd.dat_re  = (cnt_r != 3'd4);
        if (cnt_r != 3'd0) begin
          cmd.emit   = 1'b1;
          cmd.resp   = mlc_pkg::RESP_FLUSH;
          cmd.msg    = mlc_pkg::MSG_FLUSH;
          cmd.lstate = ns_r;
          cmd.fwi    = cnt_m1[1:0];
          cmd.last   = (cnt_r == 3'd4);
        end
        if (cnt_r == 3'd4) begin
          cnt_nxt   = 3'd0;
          state_nxt = fill_r ? S_WRITE : S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_WRITE: begin
        cmd.dat_we   = 1'b1;
        cmd.dat_fill = 1'b1;
        cmd.cnt_sel  = 1'b1;
        cmd.cnt      = cnt_r[1:0];
        cnt_nxt      = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          cmd.st_we  = 1'b1;
          cmd.st_val = ns_r;
          cmd.tag_we = 1'b1;
          cmd.lru_we = 1'b1;
          cmd.emit   = !fl_r;
          cmd.resp   = mlc_pkg::RESP_INSTALLED;
          cmd.lstate = ns_r;
          cmd.last   = 1'b1;
          cnt_nxt    = 3'd0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 3'd0;
      ns_r    <= mlc_pkg::ST_I;
      fill_r  <= 1'b0;
      fl_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ns_r    <= ns_nxt;
      fill_r  <= fill_nxt;
      fl_r    <= fl_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/mesi_l1_cache_controller.sv
`default_nettype none
// Two-way write-back L1 with MESI coherence, 32-byte lines, one LRU bit per set.
// An item is taken when start is high and busy low; results appear one beat a
// cycle, each on out_strobe for a single cycle, and the receiver cannot stall.
// A load miss, store, snoop without flush or buffered fill word gives its beat
// after the registered tag/state read; a load hit gives it after the
// registered tag/state read followed by the registered data word read. A snoop
// that flushes an M line gives four beats; a line install writes four new words,
// after four flush beats when an M victim is flushed first, because the single
// data port reads the four victim words and then writes the four new words.
// busy is low again in the cycle of the last beat; after a victim flush it
// stays high until the fourth new word is written.
module mesi_l1_cache_controller (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire  [1:0]                  in_req_type,
  input  wire  [mlc_pkg::AddrW-1:0]   in_addr,
  input  wire  [mlc_pkg::WordW-1:0]   in_write_data,
  input  wire  [1:0]                  in_word_index,
  input  wire                         in_shared,
  input  wire  [1:0]                  in_snoop_kind,
  input  wire                         cfg_we,
  input  wire  [3:0]                  cfg_wdata,
  output logic                        out_strobe,
  output logic [2:0]                  out_resp,
  output logic [mlc_pkg::WordW-1:0]   out_read_data,
  output logic [2:0]                  out_bus_msg,
  output logic [mlc_pkg::AddrW-1:0]   out_bus_addr,
  output logic [3:0]                  out_requester_id,
  output logic [1:0]                  out_flush_word_index,
  output logic [1:0]                  out_line_state,
  output logic                        out_last
);

  mlc_pkg::cmd_t  cmd;
  mlc_pkg::stat_t stat;

  mlc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mlc_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_req_type          (in_req_type),
    .in_addr              (in_addr),
    .in_write_data        (in_write_data),
    .in_word_index        (in_word_index),
    .in_shared            (in_shared),
    .in_snoop_kind        (in_snoop_kind),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_strobe           (out_strobe),
    .out_resp             (out_resp),
    .out_read_data        (out_read_data),
    .out_bus_msg          (out_bus_msg),
    .out_bus_addr         (out_bus_addr),
    .out_requester_id     (out_requester_id),
    .out_flush_word_index (out_flush_word_index),
    .out_line_state       (out_line_state),
    .out_last             (out_last)
  );

  a_no_beat_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_strobe)
    else $error("beat one cycle after acceptance");

  a_more_beats_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> busy)
    else $error("non-final beat while idle");

  a_flush_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_resp == mlc_pkg::RESP_FLUSH) |-> out_bus_msg == mlc_pkg::MSG_FLUSH)
    else $error("flush beat without Flush request");

  a_no_msg_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bus_msg == mlc_pkg::MSG_NONE) |->
      (out_bus_addr == '0 && out_requester_id == 4'd0))
    else $error("address or id on a beat without bus request");

endmodule
`default_nettype wire
